/* hdl/mm_pkg.sv */
// mm_pkg: shared types and constants for the matrix multiply core
// no dependencies
`default_nettype none
package mm_pkg;
	localparam int ELEM_W = 32;
	localparam int DIM_W  = 4;
	localparam int IDX_W  = 3;
	localparam int ACC_W  = 72;

	typedef logic signed [ELEM_W-1:0] elem_t;
	typedef logic signed [ACC_W-1:0]  acc_t;

	// register indexes
	localparam logic [1:0] REG_ROWS_A = 2'd0;
	localparam logic [1:0] REG_COLS_A = 2'd1;
	localparam logic [1:0] REG_ROWS_B = 2'd2;
	localparam logic [1:0] REG_COLS_B = 2'd3;

	// control word handed from the sequencer to the mac cells
	typedef struct packed {
		logic             vld;
		logic             first;
		logic             last_k;
		logic [IDX_W-1:0] row;
		logic [IDX_W-1:0] col;
		logic             last_elem;
		logic             err;
	} mac_ctl_t;
endpackage
`default_nettype wire

/* hdl/mm_mac_cell.sv */
// mm_mac_cell: one cell of the mac chain, registered product or accumulate step
// depends on mm_pkg
`default_nettype none
module mm_mac_cell #(
	parameter int MODE = 0
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  mm_pkg::mac_ctl_t      ctl_in,
	input  mm_pkg::elem_t         a_in,
	input  mm_pkg::elem_t         b_in,
	input  mm_pkg::acc_t          acc_in,
	output mm_pkg::mac_ctl_t      ctl_out,
	output mm_pkg::acc_t          acc_out
);
	// control moves to the next cell every cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_out <= '0;
		end else begin
			ctl_out <= ctl_in;
		end
	end

	// mode 0: multiply; mode 1: accumulate onto running sum
	always_ff @(posedge clk) begin
		if (MODE == 0) begin
			acc_out <= mm_pkg::ACC_W'(a_in * b_in);
		end else if (ctl_in.vld) begin
			acc_out <= ctl_in.first ? acc_in : acc_out + acc_in;
		end
	end
endmodule
`default_nettype wire

/* hdl/matrix_multiply_core.sv */
// matrix_multiply_core: top level, element stores, sequencer and mac chain
// depends on mm_pkg, mm_mac_cell
//
// Usage: elements of A then B arrive on elem_value, each taken when start is
// high and busy low, row-major. Shapes come from four 4-bit registers
// written on the cfg channel (cfg_valid/cfg_ready, cfg_index, cfg_data) while
// idle; cfg_ready is low while busy. 0 reads as 1, values above MAX_DIM as MAX_DIM.
// Loading takes one element per cycle while start is high. After the last B
// element busy rises and the product is produced row-major: each element's
// cols_a terms pass through a single multiplier cell followed by an
// accumulator cell, plus a saturation stage. The output pipe drains per
// element: the next element is issued only once the last one has left the chain.
// Results appear on prod_value and friends for one cycle under out_valid;
// the receiver cannot stall. Reset clears the load position and registers
// (all dims 4); store contents are undefined until written.
`default_nettype none
module matrix_multiply_core #(
	parameter int MAX_DIM   = 8,
	parameter int FRAC_BITS = 16
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      start,
	output logic                           busy,
	input  wire logic signed [31:0]        elem_value,
	input  wire logic                      cfg_valid,
	output logic                           cfg_ready,
	input  wire logic [1:0]                cfg_index,
	input  wire logic [3:0]                cfg_data,
	output logic                           out_valid,
	output logic signed [31:0]             prod_value,
	output logic [2:0]                     out_row,
	output logic [2:0]                     out_col,
	output logic                           last_elem,
	output logic                           size_error,
	output logic                           saturated
);
	localparam int DEPTH = MAX_DIM * MAX_DIM;
	localparam int AW    = $clog2(DEPTH);

	typedef enum logic [1:0] {ST_LOAD, ST_RUN, ST_DRAIN} st_t;

	logic [3:0] rows_a_q, cols_a_q, rows_b_q, cols_b_q;
	logic [3:0] ra, ca, rb, cb;
	st_t        st_q;
	logic       loading_b_q;
	logic [6:0] load_count_q;
	logic [2:0] i_q, j_q, k_q;
	logic [2:0] drain_q;
	logic [AW-1:0] a_addr, b_addr;
	mm_pkg::elem_t a_mem [DEPTH];
	mm_pkg::elem_t b_mem [DEPTH];
	mm_pkg::elem_t a_rd_s1, b_rd_s1;
	mm_pkg::mac_ctl_t ctl_s0, ctl_s1, ctl_s2, ctl_s3;
	mm_pkg::acc_t     prod_s2, acc_s3;
	logic [7:0] tot_a, tot_b;
	logic [6:0] cnt_nx;
	logic       take;

	function automatic logic [3:0] dim_of(input logic [3:0] r);
		if (r == 4'd0) return 4'd1;
		if (r > 4'(MAX_DIM)) return 4'(MAX_DIM);
		return r;
	endfunction

	assign ra = dim_of(rows_a_q);
	assign ca = dim_of(cols_a_q);
	assign rb = dim_of(rows_b_q);
	assign cb = dim_of(cols_b_q);
	assign tot_a = 8'(ra) * 8'(ca);
	assign tot_b = 8'(rb) * 8'(cb);
	assign cfg_ready = !busy;
	assign busy = (st_q != ST_LOAD);
	assign take = start && !busy;
	assign cnt_nx = load_count_q + 7'd1;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_a_q <= 4'd4;
			cols_a_q <= 4'd4;
			rows_b_q <= 4'd4;
			cols_b_q <= 4'd4;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				mm_pkg::REG_ROWS_A: rows_a_q <= cfg_data;
				mm_pkg::REG_COLS_A: cols_a_q <= cfg_data;
				mm_pkg::REG_ROWS_B: rows_b_q <= cfg_data;
				mm_pkg::REG_COLS_B: cols_b_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// element stores, one write port and registered read each
	always_ff @(posedge clk) begin
		if (take && !loading_b_q) a_mem[load_count_q[AW-1:0]] <= elem_value;
		if (take && loading_b_q)  b_mem[load_count_q[AW-1:0]] <= elem_value;
		a_rd_s1 <= a_mem[a_addr];
		b_rd_s1 <= b_mem[b_addr];
	end

	// addresses of the current dot product term
	always_comb begin
		logic [7:0] ai, bi;
		ai = 8'(i_q) * 8'(ca) + 8'(k_q);
		bi = 8'(k_q) * 8'(cb) + 8'(j_q);
		a_addr = ai[AW-1:0];
		b_addr = bi[AW-1:0];
	end

	// issue control for the current term
	always_comb begin
		ctl_s0.vld       = (st_q == ST_RUN);
		ctl_s0.first     = (k_q == 3'd0);
		ctl_s0.last_k    = ({1'b0, k_q} == ca - 4'd1);
		ctl_s0.row       = i_q;
		ctl_s0.col       = j_q;
		ctl_s0.last_elem = ({1'b0, i_q} == ra - 4'd1) && ({1'b0, j_q} == cb - 4'd1);
		ctl_s0.err       = (ca != rb);
	end

	// load counter and product sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_LOAD;
			loading_b_q <= 1'b0;
			load_count_q <= '0;
			i_q <= '0;
			j_q <= '0;
			k_q <= '0;
			drain_q <= '0;
		end else begin
			unique case (st_q)
				ST_LOAD: begin
					if (take) begin
						if (!loading_b_q) begin
							if (8'(cnt_nx) >= tot_a) begin
								load_count_q <= '0;
								loading_b_q <= 1'b1;
							end else load_count_q <= cnt_nx;
						end else if (8'(cnt_nx) >= tot_b) begin
							load_count_q <= '0;
							loading_b_q <= 1'b0;
							st_q <= ST_RUN;
							i_q <= '0;
							j_q <= '0;
							k_q <= '0;
						end else load_count_q <= cnt_nx;
					end
				end
				ST_RUN: begin
					if (ctl_s0.last_k) begin
						k_q <= '0;
						st_q <= ST_DRAIN;
						drain_q <= 3'd3;
					end else k_q <= k_q + 3'd1;
				end
				ST_DRAIN: begin
					if (drain_q == 3'd0) begin
						if (ctl_s0.last_elem) st_q <= ST_LOAD;
						else begin
							st_q <= ST_RUN;
							if ({1'b0, j_q} == cb - 4'd1) begin
								j_q <= '0;
								i_q <= i_q + 3'd1;
							end else j_q <= j_q + 3'd1;
						end
					end else drain_q <= drain_q - 3'd1;
				end
				default: st_q <= ST_LOAD;
			endcase
		end
	end

	// stage 1 control matches the registered store read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) ctl_s1 <= '0;
		else ctl_s1 <= ctl_s0;
	end

	// multiplier cell then accumulator cell
	mm_mac_cell #(.MODE(0)) u_mul (
		.clk(clk), .arst_n(arst_n), .ctl_in(ctl_s1), .a_in(a_rd_s1), .b_in(b_rd_s1),
		.acc_in('0), .ctl_out(ctl_s2), .acc_out(prod_s2)
	);
	mm_mac_cell #(.MODE(1)) u_acc (
		.clk(clk), .arst_n(arst_n), .ctl_in(ctl_s2), .a_in('0), .b_in('0),
		.acc_in(prod_s2), .ctl_out(ctl_s3), .acc_out(acc_s3)
	);

	// shift, saturate and register the result word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid <= 1'b0;
		else out_valid <= ctl_s3.vld && ctl_s3.last_k;
	end
	always_ff @(posedge clk) begin
		mm_pkg::acc_t sh;
		sh = acc_s3 >>> FRAC_BITS;
		out_row <= ctl_s3.row;
		out_col <= ctl_s3.col;
		last_elem <= ctl_s3.last_elem;
		size_error <= ctl_s3.err;
		if (ctl_s3.err) begin
			prod_value <= '0;
			saturated <= 1'b0;
		end else if (sh > mm_pkg::acc_t'(32'sh7FFFFFFF)) begin
			prod_value <= 32'sh7FFFFFFF;
			saturated <= 1'b1;
		end else if (sh < -mm_pkg::acc_t'(64'sh80000000)) begin
			prod_value <= 32'sh80000000;
			saturated <= 1'b1;
		end else begin
			prod_value <= sh[31:0];
			saturated <= 1'b0;
		end
	end
endmodule
`default_nettype wire

/* test/mm_checker.sv */
// mm_checker: watches the config, element and product channels of the core,
// predicts each product word and compares it; depends on mm_pkg
`default_nettype none
module mm_checker #(
	parameter int MAX_DIM   = 8,
	parameter int FRAC_BITS = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic        busy,
	input  wire logic [31:0] elem_value,
	input  wire logic        cfg_valid,
	input  wire logic        cfg_ready,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [3:0]  cfg_data,
	input  wire logic        out_valid,
	input  wire logic [31:0] prod_value,
	input  wire logic [2:0]  out_row,
	input  wire logic [2:0]  out_col,
	input  wire logic        last_elem,
	input  wire logic        size_error,
	input  wire logic        saturated,
	output int               fail_count,
	output int               pending,
	output int               checked
);
	typedef struct {
		mm_pkg::elem_t val;
		logic [2:0]    row;
		logic [2:0]    col;
		logic          last;
		logic          err;
		logic          sat;
	} prod_word_t;

	prod_word_t    product_q[$];
	mm_pkg::elem_t a_mem[64];
	mm_pkg::elem_t b_mem[64];
	int            fill_pos;
	logic          filling_b;
	logic [3:0]    dim_reg[4];

	assign pending = product_q.size();

	function automatic int eff_dim(logic [3:0] r);
		if (r == 0) return 1;
		if (r > MAX_DIM) return MAX_DIM;
		return int'(r);
	endfunction

	// full product once the last word of b is in
	task automatic predict_product();
		int ra, ca, rb, cb;
		mm_pkg::acc_t sum, sh;
		prod_word_t w;
		ra = eff_dim(dim_reg[mm_pkg::REG_ROWS_A]);
		ca = eff_dim(dim_reg[mm_pkg::REG_COLS_A]);
		rb = eff_dim(dim_reg[mm_pkg::REG_ROWS_B]);
		cb = eff_dim(dim_reg[mm_pkg::REG_COLS_B]);
		for (int i = 0; i < ra; i++) begin
			for (int j = 0; j < cb; j++) begin
				w.row  = i[2:0];
				w.col  = j[2:0];
				w.last = (i == ra - 1) && (j == cb - 1);
				w.err  = (ca != rb);
				w.sat  = 1'b0;
				w.val  = '0;
				if (!w.err) begin
					sum = '0;
					for (int k = 0; k < ca; k++)
						sum += mm_pkg::acc_t'(a_mem[(i * ca + k) % 64]) *
							mm_pkg::acc_t'(b_mem[(k * cb + j) % 64]);
					sh = sum >>> FRAC_BITS;
					if (sh > mm_pkg::acc_t'(32'sh7FFFFFFF)) begin
						w.sat = 1'b1;
						w.val = 32'sh7FFFFFFF;
					end else if (sh < mm_pkg::acc_t'(-33'sh80000000)) begin
						w.sat = 1'b1;
						w.val = 32'sh80000000;
					end else begin
						w.val = sh[31:0];
					end
				end
				product_q.push_back(w);
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		prod_word_t e;
		int total;
		if (!arst_n) begin
			product_q.delete();
			fill_pos  = 0;
			filling_b = 1'b0;
			for (int r = 0; r < 4; r++) dim_reg[r] = 4'd4;
			fail_count = 0;
			checked    = 0;
		end else begin
			// compare an outgoing word with the oldest prediction
			if (out_valid) begin
				checked++;
				if (product_q.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("unexpected product word row %0d col %0d value %h",
							out_row, out_col, prod_value);
				end else begin
					e = product_q.pop_front();
					if (e.val !== prod_value || e.row !== out_row || e.col !== out_col ||
							e.last !== last_elem || e.err !== size_error ||
							e.sat !== saturated) begin
						fail_count++;
						if (fail_count <= 10)
							$display({"mismatch: exp v=%h r=%0d c=%0d l=%b e=%b s=%b",
								" / got v=%h r=%0d c=%0d l=%b e=%b s=%b"},
								e.val, e.row, e.col, e.last, e.err, e.sat, prod_value,
								out_row, out_col, last_elem, size_error, saturated);
					end
				end
			end
			// element loads, against the shape held before this edge
			if (start && !busy) begin
				if (!filling_b) begin
					a_mem[fill_pos % 64] = elem_value;
					fill_pos = (fill_pos + 1) & 7'h7F;
					total = eff_dim(dim_reg[mm_pkg::REG_ROWS_A]) *
						eff_dim(dim_reg[mm_pkg::REG_COLS_A]);
					if (fill_pos >= total) begin
						fill_pos  = 0;
						filling_b = 1'b1;
					end
				end else begin
					b_mem[fill_pos % 64] = elem_value;
					fill_pos = (fill_pos + 1) & 7'h7F;
					total = eff_dim(dim_reg[mm_pkg::REG_ROWS_B]) *
						eff_dim(dim_reg[mm_pkg::REG_COLS_B]);
					if (fill_pos >= total) begin
						fill_pos  = 0;
						filling_b = 1'b0;
						predict_product();
					end
				end
			end
			// register writes
			if (cfg_valid && cfg_ready)
				dim_reg[cfg_index] = cfg_data;
		end
	end
endmodule
`default_nettype wire

/* test/tb.sv */
// tb: stimulus and verdict for matrix_multiply_core
// depends on mm_pkg, matrix_multiply_core and mm_checker
`default_nettype none
module tb;
	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic [31:0] elem_value;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [1:0]  cfg_index;
	logic [3:0]  cfg_data;
	logic        out_valid;
	logic [31:0] prod_value;
	logic [2:0]  out_row;
	logic [2:0]  out_col;
	logic        last_elem;
	logic        size_error;
	logic        saturated;
	int          fail_count;
	int          pending;
	int          checked;
	int          cycles;
	int          words_sent;
	int          sets_run;
	logic        no_gaps;

	matrix_multiply_core dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.elem_value(elem_value), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data), .out_valid(out_valid),
		.prod_value(prod_value), .out_row(out_row), .out_col(out_col),
		.last_elem(last_elem), .size_error(size_error), .saturated(saturated)
	);

	mm_checker chk (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.elem_value(elem_value), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data), .out_valid(out_valid),
		.prod_value(prod_value), .out_row(out_row), .out_col(out_col),
		.last_elem(last_elem), .size_error(size_error), .saturated(saturated),
		.fail_count(fail_count), .pending(pending), .checked(checked)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > 400000) begin
			$display("Some tests failed");
			$finish;
		end
	end

	function automatic int gap_draw();
		if (no_gaps) return 0;
		return $urandom_range(0, 16);
	endfunction

	function automatic int dim_of(logic [3:0] r);
		if (r == 0) return 1;
		if (r > 8) return 8;
		return int'(r);
	endfunction

	// element values: small fractions, raw random, extremes
	function automatic logic [31:0] elem_draw(int kind);
		logic [31:0] pick[6];
		pick = '{32'h7FFFFFFF, 32'h80000000, 32'h0, 32'h1, 32'hFFFFFFFF, 32'h00010000};
		if (kind == 1) return 32'h7FFFFFFF;
		if (kind == 2) return 32'h80000000;
		case ($urandom_range(0, 3))
			0: return $urandom_range(0, 32'h3FFFF) - 32'h20000;
			1: return $urandom();
			2: return pick[$urandom_range(0, 5)];
			default: return $urandom_range(0, 32'h1FFFFFF) - 32'h1000000;
		endcase
	endfunction

	task automatic send_word(logic [31:0] v);
		int g;
		g = gap_draw();
		if (g > 0) begin
			start <= 1'b0;
			repeat (g) @(posedge clk);
		end
		start      <= 1'b1;
		elem_value <= v;
		do @(negedge clk); while (busy);
		@(posedge clk);
		words_sent++;
	endtask

	task automatic write_reg(logic [1:0] idx, logic [3:0] v);
		int g;
		g = gap_draw();
		if (g > 0) begin
			cfg_valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= v;
		do @(negedge clk); while (!cfg_ready);
		@(posedge clk);
	endtask

	// one shape setting, one a/b load, then wait for the product to drain
	task automatic run_set(logic [3:0] ra, logic [3:0] ca, logic [3:0] rb, logic [3:0] cb,
			int kind);
		int n;
		no_gaps = ($urandom_range(0, 3) == 0);
		write_reg(mm_pkg::REG_ROWS_A, ra);
		write_reg(mm_pkg::REG_COLS_A, ca);
		write_reg(mm_pkg::REG_ROWS_B, rb);
		write_reg(mm_pkg::REG_COLS_B, cb);
		cfg_valid <= 1'b0;
		n = dim_of(ra) * dim_of(ca) + dim_of(rb) * dim_of(cb);
		for (int i = 0; i < n; i++) send_word(elem_draw(kind));
		start <= 1'b0;
		do @(negedge clk); while (pending != 0 || busy);
		repeat (16) @(posedge clk);
		sets_run++;
	endtask

	initial begin
		logic [3:0] ra, ca, rb, cb;
		arst_n     = 1'b0;
		start      = 1'b0;
		elem_value = '0;
		cfg_valid  = 1'b0;
		cfg_index  = mm_pkg::REG_ROWS_A;
		cfg_data   = '0;
		words_sent = 0;
		sets_run   = 0;
		no_gaps    = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: positive saturation from both extremes, a short vector, shape mismatch,
		// out-of-range dimensions
		run_set(4'd1, 4'd1, 4'd1, 4'd1, 1);
		run_set(4'd1, 4'd1, 4'd1, 4'd1, 2);
		run_set(4'd1, 4'd2, 4'd2, 4'd1, 0);
		run_set(4'd1, 4'd2, 4'd1, 4'd1, 0);
		run_set(4'd0, 4'd15, 4'd9, 4'd0, 0);

		// random shapes, mostly small and matching
		run_set(4'd8, 4'd8, 4'd8, 4'd8, 0);
		while (words_sent < 200) begin
			ra = 4'($urandom_range(1, 4));
			ca = 4'($urandom_range(1, 4));
			cb = 4'($urandom_range(1, 4));
			if ($urandom_range(0, 7) == 0) ra = 4'd8;
			if ($urandom_range(0, 9) == 0) cb = ($urandom_range(0, 1) == 0) ? 4'd0
				: 4'($urandom_range(9, 15));
			rb = ca;
			if ($urandom_range(0, 5) == 0) rb = 4'($urandom_range(0, 15));
			run_set(ra, ca, rb, cb, 0);
		end

		$display("loaded %0d elements over %0d shape settings, checked %0d product words",
			words_sent, sets_run, checked);
		if (fail_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end
endmodule
`default_nettype wire

/* sim.f */
hdl/mm_pkg.sv
hdl/mm_mac_cell.sv
hdl/matrix_multiply_core.sv
test/mm_checker.sv
test/tb.sv
